@@ src/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer package
// Shared types for the I2C master transfer block: item commands and the
// bus sequencer phases.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command carried by each input transaction
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_e;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_TX_ADDR  = 4'd2,
    PH_ACK_ADDR = 4'd3,
    PH_TX_DATA  = 4'd4,
    PH_ACK_DATA = 4'd5,
    PH_RX_BIT   = 4'd6,
    PH_RX_END   = 4'd7,
    PH_SEND_ACK = 4'd8,
    PH_STOP     = 4'd9
  } phase_e;

  // Bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

endpackage : i2cm_pkg

@@ src/i2c_master_transfer.sv @@
// ----------------------------------------------------------------------------
// I2C master transfer
// Runs one I2C read or write transfer of up to MAX_BYTES data bytes, one
// bus time quantum per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: a tick (one bus quantum, sda_in_i sampled where needed),
//   a write buffer load, or a read or write start. Each accepted input
//   transaction produces exactly one result transaction on the output
//   channel (out_valid_o / out_stall_i) holding the SCL/SDA drive levels
//   (1 = released, 0 = driven low), busy, done/success and any received byte.
//   The result is registered at the edge that accepts the input. Throughput
//   is one transaction per cycle while the output is not stalled; all work
//   for a transaction is one pass through the sequencer logic into the
//   state and result registers.
//   When the receiver stalls, the result register holds and in_stall_o is
//   raised, so no further input is accepted until the result is taken.
//   Reset puts the sequencer in idle with both lines released and the
//   result register empty. Write buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transfer #(
  parameter int MAX_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic       sda_in_i,
  input  logic [7:0] device_address_i,
  input  logic [7:0] transfer_length_i,
  input  logic [2:0] load_index_i,
  input  logic [7:0] load_byte_i,
  // Output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       success_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic [2:0] read_index_o
);
  import i2cm_pkg::*;

  // Byte counter width: holds MAX_BYTES, and at least 3 bits for the index
  localparam int CNTW = ($clog2(MAX_BYTES + 1) < 3) ? 3 : $clog2(MAX_BYTES + 1);
  // Write buffer index width
  localparam int IDXW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_BYTES);

  // Handshake
  logic in_fire;
  logic out_valid_q;

  // Sequencer state
  phase_e          phase_q, phase_d;
  logic [1:0]      step_q, step_d;
  logic [3:0]      bit_q, bit_d;
  logic [CNTW-1:0] byte_q, byte_d;
  logic [CNTW-1:0] rem_q, rem_d;
  logic [7:0]      shift_q, shift_d;
  logic            is_read_q, is_read_d;
  logic            ok_q, ok_d;
  logic            scl_q, scl_d;
  logic            sda_q, sda_d;

  // Write buffer
  logic [7:0]      wbuf_q [MAX_BYTES];
  logic            wbuf_we;
  logic [IDXW-1:0] wbuf_widx;
  logic [7:0]      wbuf_rdata;

  // Result fields for this transaction
  logic       res_done, res_succ, res_rvalid;
  logic [7:0] res_rbyte;
  logic [2:0] res_ridx;
  logic       len_bad, is_start, is_tick;
  logic [3:0] bit_inc;

  // Result register
  logic       busy_q, done_q, succ_q, rvalid_q;
  logic [7:0] rbyte_q;
  logic [2:0] ridx_q;

  mode_e mode;
  assign mode = mode_e'(mode_i);

  // Accept when the result register is empty or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign is_tick  = (mode == MODE_TICK);
  assign is_start = (mode == MODE_READ) || (mode == MODE_WRITE);
  assign len_bad  = (transfer_length_i > MaxLen);
  assign bit_inc  = bit_q + 4'd1;

  // Buffer write port and the slot for the next transmitted byte
  assign wbuf_we    = in_fire && (mode == MODE_LOAD) && (32'(load_index_i) < MAX_BYTES);
  assign wbuf_widx  = IDXW'(load_index_i);
  assign wbuf_rdata = wbuf_q[byte_q[IDXW-1:0]];

  // Next state
  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    rem_d     = rem_q;
    shift_d   = shift_q;
    is_read_d = is_read_q;
    ok_d      = ok_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    unique case (mode)
      MODE_LOAD: begin
      end
      MODE_READ, MODE_WRITE: begin
        if (phase_q == PH_IDLE && !len_bad) begin
          is_read_d = (mode == MODE_READ);
          shift_d   = (mode == MODE_READ) ? (device_address_i | 8'h01) : device_address_i;
          rem_d     = CNTW'(transfer_length_i);
          byte_d    = '0;
          bit_d     = '0;
          ok_d      = 1'b1;
          phase_d   = PH_START;
          step_d    = 2'd0;
        end
      end
      MODE_TICK: begin
        step_d = step_q + 2'd1;
        unique case (phase_q)
          PH_START: begin
            if (step_q == 2'd0) begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end else if (step_q == 2'd1 || step_q == 2'd2) begin
              sda_d = 1'b0;
            end else begin
              scl_d   = 1'b0;
              bit_d   = '0;
              phase_d = PH_TX_ADDR;
              step_d  = 2'd0;
            end
          end
          PH_TX_ADDR, PH_TX_DATA: begin
            if (step_q == 2'd0) begin
              scl_d = 1'b0;
            end else if (step_q == 2'd1) begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
            end else begin
              scl_d  = 1'b1;
              bit_d  = bit_inc;
              step_d = 2'd0;
              if (bit_inc >= BYTE_BITS) begin
                phase_d = (phase_q == PH_TX_ADDR) ? PH_ACK_ADDR : PH_ACK_DATA;
              end
            end
          end
          PH_ACK_ADDR, PH_ACK_DATA: begin
            if (step_q == 2'd0) begin
              scl_d = 1'b0;
              sda_d = 1'b1;
            end else if (step_q == 2'd2) begin
              scl_d = 1'b1;
              ok_d  = !sda_in_i;
            end else if (step_q == 2'd3) begin
              scl_d  = 1'b0;
              step_d = 2'd0;
              if (!ok_q) begin
                phase_d = PH_STOP;
              end else if (phase_q == PH_ACK_ADDR) begin
                if (is_read_q) begin
                  bit_d   = '0;
                  shift_d = '0;
                  phase_d = PH_RX_BIT;
                end else if (rem_q == '0) begin
                  phase_d = PH_STOP;
                end else begin
                  shift_d = wbuf_rdata;
                  bit_d   = '0;
                  phase_d = PH_TX_DATA;
                end
              end else begin
                // Data byte acknowledged: count it, then next byte or STOP
                byte_d = byte_q + CNTW'(1);
                if (rem_q != '0) begin
                  rem_d = rem_q - CNTW'(1);
                end
                if (rem_q <= CNTW'(1)) begin
                  phase_d = PH_STOP;
                end else begin
                  shift_d = wbuf_q[byte_d[IDXW-1:0]];
                  bit_d   = '0;
                  phase_d = PH_TX_DATA;
                end
              end
            end
          end
          PH_RX_BIT: begin
            if (step_q == 2'd0) begin
              scl_d = 1'b0;
              sda_d = 1'b1;
            end else begin
              scl_d   = 1'b1;
              shift_d = {shift_q[6:0], sda_in_i};
              bit_d   = bit_inc;
              step_d  = 2'd0;
              if (bit_inc >= BYTE_BITS) begin
                phase_d = PH_RX_END;
              end
            end
          end
          PH_RX_END: begin
            scl_d   = 1'b0;
            phase_d = PH_SEND_ACK;
            step_d  = 2'd0;
          end
          PH_SEND_ACK: begin
            if (step_q == 2'd0) begin
              sda_d = (rem_q <= CNTW'(1));
            end else if (step_q == 2'd1) begin
              scl_d = 1'b1;
            end else begin
              scl_d  = 1'b0;
              byte_d = byte_q + CNTW'(1);
              step_d = 2'd0;
              if (rem_q != '0) begin
                rem_d = rem_q - CNTW'(1);
              end
              if (rem_q <= CNTW'(1)) begin
                phase_d = PH_STOP;
              end else begin
                bit_d   = '0;
                shift_d = '0;
                phase_d = PH_RX_BIT;
              end
            end
          end
          PH_STOP: begin
            if (step_q == 2'd0) begin
              sda_d = 1'b0;
              scl_d = 1'b0;
            end else if (step_q == 2'd1) begin
              scl_d = 1'b1;
            end else if (step_q == 2'd3) begin
              sda_d   = 1'b1;
              phase_d = PH_IDLE;
              step_d  = 2'd0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            step_d  = 2'd0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_done   = 1'b0;
    res_succ   = 1'b0;
    res_rvalid = 1'b0;
    res_rbyte  = '0;
    res_ridx   = '0;
    if (is_start && phase_q == PH_IDLE && len_bad) begin
      res_done = 1'b1;
    end
    if (is_tick && phase_q == PH_STOP && step_q == 2'd3) begin
      res_done = 1'b1;
      res_succ = ok_q;
    end
    if (is_tick && phase_q == PH_RX_END) begin
      res_rvalid = 1'b1;
      res_rbyte  = shift_q;
      res_ridx   = byte_q[2:0];
    end
  end

  // Sequencer and line registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      step_q    <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      rem_q     <= '0;
      shift_q   <= '0;
      is_read_q <= 1'b0;
      ok_q      <= 1'b1;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      step_q    <= step_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      rem_q     <= rem_d;
      shift_q   <= shift_d;
      is_read_q <= is_read_d;
      ok_q      <= ok_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  // Write buffer storage
  always_ff @(posedge clk_i) begin
    if (wbuf_we) begin
      wbuf_q[wbuf_widx] <= load_byte_i;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      busy_q   <= (phase_d != PH_IDLE);
      done_q   <= res_done;
      succ_q   <= res_succ;
      rvalid_q <= res_rvalid;
      rbyte_q  <= res_rbyte;
      ridx_q   <= res_ridx;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = scl_q;
  assign sda_level_o  = sda_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign success_o    = succ_q;
  assign read_valid_o = rvalid_q;
  assign read_byte_o  = rbyte_q;
  assign read_index_o = ridx_q;

  // A received byte is only presented in the middle of a transfer
  a_rx_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rvalid_q |-> busy_q)
    else $error("received byte presented while not busy");

  // Success is only reported together with done
  a_succ_with_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && succ_q |-> done_q)
    else $error("success without done");

  // A finished transfer leaves the sequencer idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q && phase_q == PH_IDLE)
    else $error("done reported while sequencer still active");

  // Remaining byte count never exceeds the buffer depth during a transfer
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> 32'(rem_q) <= MAX_BYTES)
    else $error("remaining length out of range");

  // Input is held off only by a stalled, full result register
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without a pending result");

endmodule : i2c_master_transfer
